>>> rtl/rsk_pkg.sv
// ----------------------------------------------------------------------------
// rsk_pkg: shared types and constants of the record sorter
// Word layouts, register indexes, key codes and the command/status structs.
// ----------------------------------------------------------------------------
package rsk_pkg;

    localparam int NAME_W   = 64;
    localparam int PRICE_W  = 31;
    localparam int RATING_W = 10;
    localparam int CFG_W    = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_SORT_KEY   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DESCENDING = 1'b1;

    localparam logic [1:0] KEY_NAME   = 2'd0;
    localparam logic [1:0] KEY_PRICE  = 2'd1;

    typedef struct packed {
        logic [NAME_W-1:0]   item_name;
        logic [PRICE_W-1:0]  item_price;
        logic [RATING_W-1:0] item_rating;
        logic                last_item;
    } t_in_word;

    typedef struct packed {
        logic [NAME_W-1:0]   out_name;
        logic [PRICE_W-1:0]  out_price;
        logic [RATING_W-1:0] out_rating;
        logic                out_last;
        logic                overflowed;
    } t_out_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // write the input word at the fill count
        logic drop;      // store full: flag overflow
        logic sel_init;  // start a selection pass
        logic sel_step;  // examine one candidate
        logic emit;      // read out the chosen record
        logic clear;     // set finished: empty the store
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic scan_done;   // candidate index has passed the last record
        logic emit_last;   // this emit is the final record
    } t_status;

    // Normalize a name: keep NAME_CHARS bytes, clear all after the first zero.
    function automatic logic [NAME_W-1:0] norm_name(input logic [NAME_W-1:0] raw,
                                                    input int chars);
        logic [NAME_W-1:0] v;
        logic              hit;
        v   = raw;
        hit = 1'b0;
        for (int b = 0; b < 8; b++) begin
            if (b >= chars) hit = 1'b1;
            if (v[63-8*b -: 8] == 8'd0) hit = 1'b1;
            if (hit) v[63-8*b -: 8] = 8'd0;
        end
        return v;
    endfunction

endpackage

>>> rtl/rsk_datapath.sv
// ----------------------------------------------------------------------------
// rsk_datapath: record store and selection unit
// Holds the loaded records and finds, one candidate per cycle, the next record
// in sorted order. Emitted records are marked used by a per-entry bit.
// ----------------------------------------------------------------------------
module rsk_datapath
    import rsk_pkg::*;
#(
    parameter int MAX_ITEMS  = 32,
    parameter int NAME_CHARS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_word  i_word,
    input  logic [1:0] i_sort_key,
    input  logic      i_descending,
    input  t_cmd      i_cmd,
    output t_status   o_status,
    output t_out_word o_word
);
    localparam int IW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);

    logic [NAME_W-1:0]   r_name  [MAX_ITEMS];
    logic [PRICE_W-1:0]  r_price [MAX_ITEMS];
    logic [RATING_W-1:0] r_rating[MAX_ITEMS];
    logic [MAX_ITEMS-1:0] r_used;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_emitted;
    logic          r_ovf;
    logic [CW-1:0] r_scan;
    logic          r_have;
    logic [IW-1:0] r_best;
    logic [NAME_W-1:0] r_best_key;

    logic [NAME_W-1:0] w_key;
    logic [IW-1:0]     w_idx;
    logic              w_better;
    logic              w_cand;

    assign w_idx = r_scan[IW-1:0];

    always_comb begin
        case (i_sort_key)
            KEY_NAME:  w_key = r_name[w_idx];
            KEY_PRICE: w_key = {{(NAME_W-PRICE_W){1'b0}}, r_price[w_idx]};
            default:   w_key = {{(NAME_W-RATING_W){1'b0}}, r_rating[w_idx]};
        endcase
    end

    // Strict compare keeps the earliest of equal keys: stable order.
    assign w_cand   = (r_scan < r_count) && !r_used[w_idx];
    assign w_better = !r_have ||
        (i_descending ? (w_key > r_best_key) : (w_key < r_best_key));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_name[r_count[IW-1:0]]   <= norm_name(i_word.item_name, NAME_CHARS);
            r_price[r_count[IW-1:0]]  <= i_word.item_price;
            r_rating[r_count[IW-1:0]] <= i_word.item_rating;
        end
        if (i_cmd.sel_step && w_cand && w_better) begin
            r_best     <= w_idx;
            r_best_key <= w_key;
        end
        if (i_cmd.emit) begin
            o_word.out_name   <= r_name[r_best];
            o_word.out_price  <= r_price[r_best];
            o_word.out_rating <= r_rating[r_best];
            o_word.out_last   <= (r_emitted + 1'b1 == r_count);
            o_word.overflowed <= r_ovf;
        end
        if (!i_rst_n) begin
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_used    <= '0;
            r_emitted <= '0;
            r_scan    <= '0;
            r_have    <= 1'b0;
        end else begin
            if (i_cmd.load) r_count <= r_count + 1'b1;
            if (i_cmd.drop) r_ovf <= 1'b1;
            if (i_cmd.sel_init) begin
                r_scan <= '0;
                r_have <= 1'b0;
            end else if (i_cmd.sel_step) begin
                r_scan <= r_scan + 1'b1;
                if (w_cand) r_have <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_used[r_best] <= 1'b1;
                r_emitted      <= r_emitted + 1'b1;
            end
            if (i_cmd.clear) begin
                r_count   <= '0;
                r_ovf     <= 1'b0;
                r_used    <= '0;
                r_emitted <= '0;
            end
        end
    end

    assign o_status.full      = (r_count == CW'(MAX_ITEMS));
    assign o_status.scan_done = (r_scan >= r_count);
    assign o_status.emit_last = (r_emitted + 1'b1 == r_count);

endmodule

>>> rtl/rsk_ctrl.sv
// ----------------------------------------------------------------------------
// rsk_ctrl: sequencer of the record sorter
// Loads words while idle; after the last word runs one selection pass per
// output record and strobes each result.
// ----------------------------------------------------------------------------
module rsk_ctrl
    import rsk_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_last,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy,
    output logic    o_valid
);
    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EMIT} t_state;
    t_state r_state;
    logic   r_valid;
    logic   r_fin;

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load     = i_start && !i_status.full;
                o_cmd.drop     = i_start && i_status.full;
                o_cmd.sel_init = 1'b1;
            end
            S_SCAN: o_cmd.sel_step = 1'b1;
            S_EMIT: begin
                o_cmd.emit     = 1'b1;
                o_cmd.sel_init = 1'b1;
                o_cmd.clear    = i_status.emit_last;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_fin   <= 1'b0;
        end else begin
            r_valid <= (r_state == S_EMIT);
            r_fin   <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_start && i_last) r_state <= S_SCAN;
                S_SCAN: if (i_status.scan_done) r_state <= S_EMIT;
                S_EMIT: begin
                    if (i_status.emit_last) begin
                        r_state <= S_IDLE;
                        r_fin   <= 1'b1;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Busy until the final result word has been shown.
    assign o_busy  = (r_state != S_IDLE) || r_fin;
    assign o_valid = r_valid;

endmodule

>>> rtl/record_sorter_by_key.sv
// ----------------------------------------------------------------------------
// record_sorter_by_key: stable sort of a loaded record set
//   channel | handshake          | payload
//   input   | i_start / o_busy   | i_in  (t_in_word)
//   output  | o_valid strobe     | o_out (t_out_word)
//   config  | i_cfg_we, i_cfg_idx| i_cfg_data
// Records load while the sorter is idle. After the marked word, each record
// is found by a selection scan over the store (one entry per cycle) followed
// by an emit step. Reset is synchronous and empties the store. The receiver
// cannot stall; busy holds new words off.
// ----------------------------------------------------------------------------
module record_sorter_by_key
    import rsk_pkg::*;
#(
    parameter int MAX_ITEMS  = 32,
    parameter int NAME_CHARS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  t_in_word             i_in,
    output logic                 o_valid,
    output t_out_word            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);
    logic [1:0] r_sort_key;
    logic       r_descending;
    t_cmd       w_cmd;
    t_status    w_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sort_key   <= KEY_NAME;
            r_descending <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SORT_KEY:   r_sort_key   <= i_cfg_data;
                REG_DESCENDING: r_descending <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    rsk_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start && !o_busy),
        .i_last   (i_in.last_item),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (o_busy),
        .o_valid  (o_valid)
    );

    rsk_datapath #(
        .MAX_ITEMS  (MAX_ITEMS),
        .NAME_CHARS (NAME_CHARS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_word       (i_in),
        .i_sort_key   (r_sort_key),
        .i_descending (r_descending),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .o_word       (o_out)
    );

endmodule

>>> verif/record_sorter_by_key_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// record_sorter_by_key_test: self-checking bench for the record sorter
// Loads record sets of random size with random names, prices and ratings,
// predicts the stably sorted output of each set and checks every output word
// against it, while the sort key and direction are changed between phases.
// ----------------------------------------------------------------------------
module record_sorter_by_key_test;
    import rsk_pkg::*;

    localparam int CAP   = 32;
    localparam int CHARS = 8;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_start;
    logic                 o_busy;
    t_in_word             i_in;
    logic                 o_valid;
    t_out_word            o_out;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    record_sorter_by_key #(.MAX_ITEMS(CAP), .NAME_CHARS(CHARS)) dut (.*);

    // Predictor state.
    logic [NAME_W-1:0]   names   [CAP];
    logic [PRICE_W-1:0]  prices  [CAP];
    logic [RATING_W-1:0] ratings [CAP];
    int                  fill;
    logic                dropped;
    logic [1:0]          key_sel;
    logic                desc_mode;

    t_in_word  pending_words[$];
    t_out_word sorted_words[$];
    int        mismatches;
    int        errors;
    bit        calm;

    // Busy as seen at the last rising edge, for the driver's acceptance test.
    logic o_busy_q;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [NAME_W-1:0] clean_name(logic [NAME_W-1:0] raw);
        logic [NAME_W-1:0] v;
        logic              ended;
        v     = raw;
        ended = 1'b0;
        for (int b = 0; b < 8; b++) begin
            if (b >= CHARS || v[63-8*b -: 8] == 8'd0) ended = 1'b1;
            if (ended) v[63-8*b -: 8] = 8'd0;
        end
        return v;
    endfunction

    function automatic logic [63:0] sort_field(int idx);
        if (key_sel == KEY_NAME) return names[idx];
        if (key_sel == KEY_PRICE) return 64'(prices[idx]);
        return 64'(ratings[idx]);
    endfunction

    // Stores one accepted word; a marked word emits the set in sorted order.
    task automatic predict_sort(t_in_word w);
        int        order[CAP];
        int        j;
        logic [63:0] ka;
        logic [63:0] kb;
        t_out_word r;
        if (fill < CAP) begin
            names[fill]   = clean_name(w.item_name);
            prices[fill]  = w.item_price;
            ratings[fill] = w.item_rating;
            fill++;
        end else begin
            dropped = 1'b1;
        end
        if (!w.last_item) return;
        for (int i = 0; i < fill; i++) begin
            j  = i;
            ka = sort_field(i);
            while (j > 0) begin
                kb = sort_field(order[j-1]);
                if (!(desc_mode ? (ka > kb) : (ka < kb))) break;
                order[j] = order[j-1];
                j--;
            end
            order[j] = i;
        end
        for (int k = 0; k < fill; k++) begin
            r.out_name   = names[order[k]];
            r.out_price  = prices[order[k]];
            r.out_rating = ratings[order[k]];
            r.out_last   = (k == fill - 1);
            r.overflowed = dropped;
            sorted_words.push_back(r);
        end
        fill    = 0;
        dropped = 1'b0;
    endtask

    // Driver: offers the next pending word, idling now and then.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else if (i_start && !o_busy_q) begin
            // Previous word was taken at the last rising edge.
            if (pending_words.size() > 0 && (calm || $urandom_range(99) >= 19)) begin
                i_in    <= pending_words.pop_front();
                i_start <= 1'b1;
            end else begin
                i_start <= 1'b0;
            end
        end else if (!i_start) begin
            if (pending_words.size() > 0 && (calm || $urandom_range(99) >= 19)) begin
                i_in    <= pending_words.pop_front();
                i_start <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) o_busy_q <= o_busy;

    // Monitor: predicts on acceptance and checks each output word.
    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (i_rst_n && i_start && !o_busy) predict_sort(i_in);
        if (i_rst_n && o_valid) begin
            if (sorted_words.size() == 0) begin
                errors++;
                if (mismatches < 10) $display("Unexpected word %h", o_out);
                mismatches++;
            end else begin
                exp_w = sorted_words.pop_front();
                if (o_out !== exp_w) begin
                    errors++;
                    if (mismatches < 10)
                        $display("Mismatch: expected %h actual %h", exp_w, o_out);
                    mismatches++;
                end
            end
        end
    end

    function automatic t_in_word make_word(logic last, int mode);
        t_in_word w;
        w.item_name = {$urandom, $urandom};
        // Zero bytes in the middle exercise the string-end clearing.
        if ($urandom_range(3) == 0) w.item_name[8*$urandom_range(7) +: 8] = 8'd0;
        // Few distinct keys make ties frequent, to check stability.
        if (mode == 1) begin
            w.item_name   = {8'h41 + 8'($urandom_range(2)), 56'd0};
            w.item_price  = 31'($urandom_range(3));
            w.item_rating = 10'($urandom_range(3));
        end else begin
            w.item_price  = 31'($urandom);
            w.item_rating = ($urandom_range(9) == 0) ? 10'($urandom) :
                            10'($urandom_range(1000));
        end
        w.last_item = last;
        return w;
    endfunction

    task automatic queue_set(int n);
        int mode;
        mode = $urandom_range(1);
        for (int i = 0; i < n; i++) pending_words.push_back(make_word(i == n - 1, mode));
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == REG_SORT_KEY) key_sel = val;
        else desc_mode = val[0];
    endtask

    task automatic drain;
        while (pending_words.size() > 0 || i_start || sorted_words.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        t_in_word w;
        i_rst_n    = 1'b0;
        i_start    = 1'b0;
        i_in       = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        fill       = 0;
        dropped    = 1'b0;
        key_sel    = KEY_NAME;
        desc_mode  = 1'b0;
        mismatches = 0;
        errors     = 0;
        calm       = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: field extremes, a single-record set, then an overfull set.
        w = '{item_name: '1, item_price: '1, item_rating: '1, last_item: 1'b0};
        pending_words.push_back(w);
        w = '{item_name: '0, item_price: '0, item_rating: '0, last_item: 1'b0};
        pending_words.push_back(w);
        w = '{item_name: 64'h4100_4243_4445_4647, item_price: 31'd5,
              item_rating: 10'd1000, last_item: 1'b1};
        pending_words.push_back(w);
        pending_words.push_back(make_word(1'b1, 0));
        drain();
        write_reg(REG_SORT_KEY, 2'd3);
        write_reg(REG_DESCENDING, 2'd1);
        queue_set(CAP + 3);
        drain();

        // Random phases over every key and direction.
        for (int phase = 0; phase < 8; phase++) begin
            write_reg(REG_SORT_KEY, CFG_W'(phase % 4));
            write_reg(REG_DESCENDING, CFG_W'(phase / 4));
            calm = (phase == 5);
            for (int s = 0; s < 7; s++) begin
                if ($urandom_range(15) == 0) queue_set(CAP + $urandom_range(2));
                else queue_set($urandom_range(1, 10));
            end
            drain();
        end

        if (errors == 0 && sorted_words.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

>>> record_sorter_by_key.f
rtl/rsk_pkg.sv
rtl/rsk_datapath.sv
rtl/rsk_ctrl.sv
rtl/record_sorter_by_key.sv
verif/record_sorter_by_key_test.sv
